// ----- rtl/brsc_pkg.sv -----
// ----------------------------------------------------------------------------
// brsc_pkg
// Shared constants and types for the resource safety checker.
// ----------------------------------------------------------------------------
`default_nettype none

package brsc_pkg;

    localparam int NUM_PROCS = 8;
    localparam int NUM_RES   = 3;

    localparam int CNT_W  = 8;
    localparam int WORK_W = 12;
    localparam int OP_W   = 3;
    localparam int PROC_W = 3;
    localparam int STAT_W = 2;

    localparam int IDX_W  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int DONE_W = $clog2(NUM_PROCS + 1);

    localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

    typedef logic [CNT_W-1:0]                 t_cnt;
    typedef logic [NUM_RES-1:0][CNT_W-1:0]    t_row;
    typedef logic [NUM_RES-1:0][WORK_W-1:0]   t_work;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_MAX   = 3'd0,
        OP_LOAD_ALLOC = 3'd1,
        OP_SET_AVAIL  = 3'd2,
        OP_REQUEST    = 3'd3,
        OP_RELEASE    = 3'd4,
        OP_CHECK      = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_UNSAFE  = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/bankers_resource_safety_checker_top.sv -----
// ----------------------------------------------------------------------------
// bankers_resource_safety_checker_top
// Deadlock-avoidance checker: max/allocation tables, available vector,
// request/release bookkeeping and an iterative safety scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation beat:
//   load max row, load allocation row, set available, request, release or
//   check. Output channel (o_out_valid / i_out_ready) returns result beats;
//   every operation ends with a beat that has o_last set.
//   A table operation runs through the execute and emit states, and the
//   next beat can be accepted once the sequencer is back in idle.
//   A check scans one process per cycle through a single compare/add row
//   unit; a pass covers NUM_PROCS processes and at most NUM_PROCS passes
//   run. A safe scan is followed by NUM_PROCS sequence beats, one per cycle
//   when not stalled; an unsafe scan ends with a single unsafe beat.
//   One item is worked on at a time; o_in_ready is high only while idle.
//   The output register lets the next beat be accepted while a result waits.
//   A stalled receiver holds the result beat and pauses the sequencer.
//   Reset clears the max and allocation tables and the available vector to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_resource_safety_checker_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [brsc_pkg::OP_W-1:0]    i_operation,
    input  wire logic [brsc_pkg::PROC_W-1:0]  i_process,
    input  wire logic [brsc_pkg::CNT_W-1:0]   i_count_0,
    input  wire logic [brsc_pkg::CNT_W-1:0]   i_count_1,
    input  wire logic [brsc_pkg::CNT_W-1:0]   i_count_2,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [brsc_pkg::STAT_W-1:0]       o_status,
    output logic [brsc_pkg::PROC_W-1:0]       o_seq_process,
    output logic                              o_last
);
    import brsc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_EMIT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic                  r_bad, n_bad;
    t_row                  r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_oidx, n_oidx;
    logic [DONE_W-1:0]     r_done, n_done;
    logic [NUM_PROCS-1:0]  r_fin, n_fin;
    logic                  r_found, n_found;
    t_work                 r_work, n_work;
    t_status               r_pend, n_pend;

    t_row                  r_max [NUM_PROCS];
    t_row                  r_alloc [NUM_PROCS];
    t_row                  r_avail;
    logic [IDX_W-1:0]      r_seq [NUM_PROCS];

    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [PROC_W-1:0]     r_out_seq, n_out_seq;
    logic                  r_out_last, n_out_last;

    // shared row unit
    t_row                  w_mrow, w_arow, w_nrow;
    t_work                 w_work_add;
    logic                  w_fits;
    logic                  w_slot;
    logic                  w_max_we, w_alloc_we, w_avail_we, w_seq_we;
    t_row                  w_alloc_d, w_avail_d;
    logic [CNT_W:0]        w_sum9;
    logic [WORK_W:0]       w_sum13;
    t_cnt                  w_cin [3];

    assign w_cin[0] = i_count_0;
    assign w_cin[1] = i_count_1;
    assign w_cin[2] = i_count_2;

    always_comb begin
        w_mrow = r_max[r_idx];
        w_arow = r_alloc[r_idx];
        w_fits = !r_fin[r_idx];
        w_sum13 = '0;
        for (int r = 0; r < NUM_RES; r++) begin
            w_nrow[r] = (w_mrow[r] >= w_arow[r]) ? (w_mrow[r] - w_arow[r]) : '0;
            if (WORK_W'(w_nrow[r]) > r_work[r]) begin
                w_fits = 1'b0;
            end
            w_sum13 = {1'b0, r_work[r]} + (WORK_W + 1)'(w_arow[r]);
            w_work_add[r] = w_sum13[WORK_W] ? WORK_MAX : w_sum13[WORK_W-1:0];
        end
    end

    assign w_slot = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_bad        = r_bad;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_oidx       = r_oidx;
        n_done       = r_done;
        n_fin        = r_fin;
        n_found      = r_found;
        n_work       = r_work;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_seq    = r_out_seq;
        n_out_last   = r_out_last;
        w_max_we     = 1'b0;
        w_alloc_we   = 1'b0;
        w_avail_we   = 1'b0;
        w_seq_we     = 1'b0;
        w_alloc_d    = r_cnt;
        w_avail_d    = r_cnt;
        w_sum9       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = t_op'(i_operation);
                    n_bad = (32'(i_process) >= 32'(NUM_PROCS));
                    n_idx = IDX_W'(i_process);
                    for (int r = 0; r < NUM_RES; r++) begin
                        n_cnt[r] = w_cin[r];
                    end
                    if (t_op'(i_operation) == OP_CHECK) begin
                        n_idx   = '0;
                        n_fin   = '0;
                        n_done  = '0;
                        n_found = 1'b0;
                        for (int r = 0; r < NUM_RES; r++) begin
                            n_work[r] = WORK_W'(r_avail[r]);
                        end
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_pend  = ST_OK;
                n_state = S_EMIT;
                case (r_op)
                    OP_SET_AVAIL: begin
                        w_avail_we = 1'b1;
                    end
                    OP_LOAD_MAX: begin
                        if (r_bad) n_pend = ST_REFUSED;
                        else w_max_we = 1'b1;
                    end
                    OP_LOAD_ALLOC: begin
                        if (r_bad) n_pend = ST_REFUSED;
                        else w_alloc_we = 1'b1;
                    end
                    OP_REQUEST: begin
                        for (int r = 0; r < NUM_RES; r++) begin
                            if (r_cnt[r] > w_nrow[r] || r_cnt[r] > r_avail[r]) begin
                                n_pend = ST_REFUSED;
                            end
                            w_avail_d[r] = r_avail[r] - r_cnt[r];
                            w_alloc_d[r] = w_arow[r] + r_cnt[r];
                        end
                        if (r_bad) n_pend = ST_REFUSED;
                        w_avail_we = (n_pend == ST_OK);
                        w_alloc_we = (n_pend == ST_OK);
                    end
                    OP_RELEASE: begin
                        for (int r = 0; r < NUM_RES; r++) begin
                            w_sum9 = {1'b0, r_avail[r]} + {1'b0, r_cnt[r]};
                            if (r_cnt[r] > w_arow[r] || w_sum9[CNT_W]) begin
                                n_pend = ST_REFUSED;
                            end
                            w_avail_d[r] = w_sum9[CNT_W-1:0];
                            w_alloc_d[r] = w_arow[r] - r_cnt[r];
                        end
                        if (r_bad) n_pend = ST_REFUSED;
                        w_avail_we = (n_pend == ST_OK);
                        w_alloc_we = (n_pend == ST_OK);
                    end
                    default: begin
                        n_pend = ST_REFUSED;
                    end
                endcase
            end
            S_SCAN: begin
                if (w_fits) begin
                    n_work        = w_work_add;
                    w_seq_we      = 1'b1;
                    n_done        = r_done + 1'b1;
                    n_fin[r_idx]  = 1'b1;
                    n_found       = 1'b1;
                end
                if (w_fits && r_done == DONE_W'(NUM_PROCS - 1)) begin
                    n_oidx  = '0;
                    n_state = S_OUT;
                end else if (r_idx == IDX_W'(NUM_PROCS - 1)) begin
                    if (!(r_found || w_fits)) begin
                        n_pend  = ST_UNSAFE;
                        n_state = S_EMIT;
                    end else begin
                        n_idx   = '0;
                        n_found = 1'b0;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend;
                    n_out_seq    = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_OUT: begin
                if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_seq    = PROC_W'(r_seq[r_oidx]);
                    n_out_last   = (r_oidx == IDX_W'(NUM_PROCS - 1));
                    n_oidx       = r_oidx + 1'b1;
                    if (r_oidx == IDX_W'(NUM_PROCS - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_avail     <= '0;
            for (int p = 0; p < NUM_PROCS; p++) begin
                r_max[p]   <= '0;
                r_alloc[p] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_max_we)   r_max[r_idx]   <= r_cnt;
            if (w_alloc_we) r_alloc[r_idx] <= w_alloc_d;
            if (w_avail_we) r_avail        <= w_avail_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_bad        <= n_bad;
        r_cnt        <= n_cnt;
        r_idx        <= n_idx;
        r_oidx       <= n_oidx;
        r_done       <= n_done;
        r_fin        <= n_fin;
        r_found      <= n_found;
        r_work       <= n_work;
        r_pend       <= n_pend;
        r_out_status <= n_out_status;
        r_out_seq    <= n_out_seq;
        r_out_last   <= n_out_last;
        if (w_seq_we) r_seq[r_done[IDX_W-1:0]] <= r_idx;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_seq_process = r_out_seq;
    assign o_last        = r_out_last;

    // a refused or unsafe beat is always a lone final beat with no process
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_seq_process == '0 && o_last)
        else $error("error beat carries a sequence entry or is not last");

    // sequence is emitted only after every process has finished
    a_all_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> &r_fin)
        else $error("sequence output with unfinished processes");

    a_done_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> 32'(r_done) < 32'(NUM_PROCS))
        else $error("finished count overran during scan");

    // an accepted beat always starts work
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == S_EXEC || r_state == S_SCAN)
        else $error("accepted beat did not start an operation");

endmodule

`default_nettype wire
